/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk, off while in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on every edge
`define CISE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define CISE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CISE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/cise_pkg.sv */
// ----------------------------------------------------------------------------
// cise_pkg
// types, opcodes and reset values for the instruction subset execute unit
// ----------------------------------------------------------------------------
package cise_pkg;

  localparam int InDataW  = 40;
  localparam int OutDataW = 72;
  localparam int OutUserW = 2;

  localparam logic [15:0] PcReset  = 16'h0100;
  localparam logic [15:0] SpReset  = 16'hFFFE;
  localparam logic [7:0]  HighPage = 8'hFF;
  localparam logic [3:0]  FlagsSub = 4'hC;

  localparam logic [7:0] OpNop   = 8'h00;
  localparam logic [7:0] OpLdHl  = 8'h21;
  localparam logic [7:0] OpLdSp  = 8'h31;
  localparam logic [7:0] OpLdA   = 8'h3E;
  localparam logic [7:0] OpSubA  = 8'h97;
  localparam logic [7:0] OpJp    = 8'hC3;
  localparam logic [7:0] OpRet   = 8'hC9;
  localparam logic [7:0] OpCall  = 8'hCD;
  localparam logic [7:0] OpLdh   = 8'hE0;
  localparam logic [7:0] OpAddSp = 8'hE8;
  localparam logic [7:0] OpLdMem = 8'hEA;
  localparam logic [7:0] OpDi    = 8'hF3;

  // opcode sits in the lowest bits
  typedef struct packed {
    logic [7:0] stack_high;
    logic [7:0] stack_low;
    logic [7:0] imm_high;
    logic [7:0] imm_low;
    logic [7:0] opcode;
  } item_t;

  typedef struct packed {
    logic [15:0] pc;
    logic [15:0] sp;
    logic [7:0]  a;
    logic [7:0]  h;
    logic [7:0]  l;
    logic [3:0]  flags;
    logic        halted;
  } regs_t;

  typedef struct packed {
    logic        write_valid;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic [15:0] next_pc;
    logic [15:0] stack_pointer;
    logic [7:0]  accumulator;
    logic [3:0]  flag_bits;
    logic        fault;
    logic        last;
  } res_t;

endpackage

/* design/cpu_instruction_subset_execute_unit.sv */
// ----------------------------------------------------------------------------
// cpu_instruction_subset_execute_unit
// executes a subset of an 8-bit cpu instruction set, one instruction per word
// ----------------------------------------------------------------------------
// Each input word is one instruction with its operand and stack bytes. It is
// registered in the input register, executed by the combinational decode/execute
// logic and its result words land in the output register.
// A new instruction is taken every cycle while the output is not stalled and no
// second push word is pending; CALL gives two result words (high byte push
// first) and so holds the output register for both of them. After an
// unimplemented opcode the unit answers every further word with a fault word
// until reset.
module cpu_instruction_subset_execute_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // opcode, imm_low, imm_high, stack_low, stack_high
  input  logic [cise_pkg::InDataW-1:0]   in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // write_address, write_data, next_pc, stack_pointer, accumulator,
  // flag_bits, zero pad
  output logic [cise_pkg::OutDataW-1:0]  out_tdata,
  // write_valid, fault
  output logic [cise_pkg::OutUserW-1:0]  out_tuser,
  output logic                           out_tlast
);
  import cise_pkg::*;

  `include "assert_macros.svh"

  logic  in_vld_r;
  item_t in_r;
  regs_t st_r;
  logic  out_vld_r;
  res_t  out_r;
  logic  pend_vld_r;
  res_t  pend_r;

  regs_t st_nxt;
  res_t  res0;
  res_t  res1;
  logic  two;
  logic  out_free;
  logic  exec_fire;

  cise_exec u_exec (
    .st     (st_r),
    .item   (in_r),
    .st_nxt (st_nxt),
    .res0   (res0),
    .res1   (res1),
    .two    (two)
  );

  assign out_free  = !out_vld_r || out_tready;
  assign exec_fire = in_vld_r && out_free && !pend_vld_r;
  assign in_tready = !in_vld_r || exec_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      pend_vld_r <= 1'b0;
      st_r.pc     <= PcReset;
      st_r.sp     <= SpReset;
      st_r.a      <= 8'd0;
      st_r.h      <= 8'd0;
      st_r.l      <= 8'd0;
      st_r.flags  <= 4'd0;
      st_r.halted <= 1'b0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
        if (in_tvalid) begin
          in_r <= item_t'(in_tdata);
        end
      end
      if (exec_fire) begin
        st_r       <= st_nxt;
        out_vld_r  <= 1'b1;
        out_r      <= res0;
        pend_vld_r <= two;
        pend_r     <= res1;
      end else if (pend_vld_r && out_free) begin
        out_vld_r  <= 1'b1;
        out_r      <= pend_r;
        pend_vld_r <= 1'b0;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'd0, out_r.flag_bits, out_r.accumulator, out_r.stack_pointer,
                       out_r.next_pc, out_r.write_data, out_r.write_address};
  assign out_tuser  = {out_r.fault, out_r.write_valid};
  assign out_tlast  = out_r.last;

  `CISE_ASSERT_IMP(a_pend_behind_out, pend_vld_r, out_vld_r, "second push word without first")
  `CISE_ASSERT_IMP(a_first_needs_pend, out_vld_r && !out_r.last, pend_vld_r, "lost second push word")
  `CISE_ASSERT_NXT(a_halt_sticks, st_r.halted, st_r.halted, "halt cleared without reset")
  `CISE_ASSERT_NXT(a_exec_gives_word, exec_fire, out_vld_r, "executed instruction left no word")

endmodule

/* design/cise_exec.sv */
// ----------------------------------------------------------------------------
// cise_exec
// decode and execute of one instruction: next register state and up to
// two result words
// ----------------------------------------------------------------------------
module cise_exec (
  input  cise_pkg::regs_t st,
  input  cise_pkg::item_t item,
  output cise_pkg::regs_t st_nxt,
  output cise_pkg::res_t  res0,
  output cise_pkg::res_t  res1,
  output logic            two
);
  import cise_pkg::*;

  logic        wr_v;
  logic [15:0] wr_a;
  logic [7:0]  wr_d;
  logic        flt;
  logic [15:0] imm16;
  logic [15:0] pc_p1;
  logic [15:0] pc_p2;
  logic [15:0] pc_p3;
  logic [15:0] sp_m1;
  logic [15:0] sp_m2;
  logic [15:0] off;
  logic [15:0] sp_add;
  logic [4:0]  nib_sum;
  logic [8:0]  byte_sum;

  assign imm16    = {item.imm_high, item.imm_low};
  assign pc_p1    = st.pc + 16'd1;
  assign pc_p2    = st.pc + 16'd2;
  assign pc_p3    = st.pc + 16'd3;
  assign sp_m1    = st.sp - 16'd1;
  assign sp_m2    = st.sp - 16'd2;
  assign off      = {{8{item.imm_low[7]}}, item.imm_low};
  assign sp_add   = st.sp + off;
  assign nib_sum  = {1'b0, st.sp[3:0]} + {1'b0, item.imm_low[3:0]};
  assign byte_sum = {1'b0, st.sp[7:0]} + {1'b0, item.imm_low};

  always_comb begin
    st_nxt = st;
    wr_v   = 1'b0;
    wr_a   = 16'd0;
    wr_d   = 8'd0;
    flt    = 1'b0;
    two    = 1'b0;
    if (st.halted) begin
      flt = 1'b1;
    end else begin
      case (item.opcode)
        OpNop, OpDi: begin
          st_nxt.pc = pc_p1;
        end
        OpLdHl: begin
          st_nxt.h  = item.imm_high;
          st_nxt.l  = item.imm_low;
          st_nxt.pc = pc_p3;
        end
        OpLdSp: begin
          st_nxt.sp = imm16;
          st_nxt.pc = pc_p3;
        end
        OpLdA: begin
          st_nxt.a  = item.imm_low;
          st_nxt.pc = pc_p2;
        end
        OpSubA: begin
          st_nxt.a     = 8'd0;
          st_nxt.flags = FlagsSub;
          st_nxt.pc    = pc_p1;
        end
        OpJp: begin
          st_nxt.pc = imm16;
        end
        OpRet: begin
          st_nxt.pc = {item.stack_high, item.stack_low};
          st_nxt.sp = st.sp + 16'd2;
        end
        OpCall: begin
          st_nxt.sp = sp_m2;
          st_nxt.pc = imm16;
          wr_v      = 1'b1;
          wr_a      = sp_m1;
          wr_d      = pc_p3[15:8];
          two       = 1'b1;
        end
        OpLdh: begin
          st_nxt.pc = pc_p2;
          wr_v      = 1'b1;
          wr_a      = {HighPage, item.imm_low};
          wr_d      = st.a;
        end
        OpAddSp: begin
          st_nxt.sp    = sp_add;
          st_nxt.flags = {2'b00, nib_sum[4], byte_sum[8]};
          st_nxt.pc    = pc_p2;
        end
        OpLdMem: begin
          st_nxt.pc = pc_p3;
          wr_v      = 1'b1;
          wr_a      = imm16;
          wr_d      = st.a;
        end
        default: begin
          st_nxt.pc     = pc_p1;
          st_nxt.halted = 1'b1;
          flt           = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    res0.write_valid   = wr_v;
    res0.write_address = wr_a;
    res0.write_data    = wr_d;
    res0.next_pc       = st_nxt.pc;
    res0.stack_pointer = st_nxt.sp;
    res0.accumulator   = st_nxt.a;
    res0.flag_bits     = st_nxt.flags;
    res0.fault         = flt;
    res0.last          = !two;

    // low byte of the return address for the second push
    res1.write_valid   = 1'b1;
    res1.write_address = sp_m2;
    res1.write_data    = pc_p3[7:0];
    res1.next_pc       = st_nxt.pc;
    res1.stack_pointer = st_nxt.sp;
    res1.accumulator   = st_nxt.a;
    res1.flag_bits     = st_nxt.flags;
    res1.fault         = 1'b0;
    res1.last          = 1'b1;
  end

endmodule
